/* hdl/block_table_bit_memory_allocator_assert.svh */
// Assertion macros for the block table bit memory allocator.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef BLOCK_TABLE_BIT_MEMORY_ALLOCATOR_ASSERT_SVH
`define BLOCK_TABLE_BIT_MEMORY_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/btbma_pkg.sv */
// Package for the block table bit memory allocator: sizes, codes, transaction types.
// No dependencies.
`default_nettype none

package btbma_pkg;

  localparam int MEM_BITS   = 1024;
  localparam int MAX_BLOCKS = 16;

  localparam int ADDR_W = $clog2(MEM_BITS);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int SUM_W  = LEN_W + 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LAST,
    S_SCAN,
    S_ZERO,
    S_SHIFT,
    S_READ
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  address;
    logic [LEN_W-1:0]   length;
    logic               bit_value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  granted_address;
    logic               read_bit;
    status_t            status;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/block_table_bit_memory_allocator.sv */
// Allocate appends after the last live block; write/read walk the table one entry per cycle;
// free walks the table to the block, clears its bits one per cycle, then closes the gap one
// entry per cycle. One transaction at a time: busy stays high until its result is issued.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all MEM_BITS (1024) bits of
// the bit memory with busy high. Results appear for one cycle on out_valid; no stall.
// Depends on btbma_pkg and block_table_bit_memory_allocator_assert.svh.
`default_nettype none

`include "block_table_bit_memory_allocator_assert.svh"

module block_table_bit_memory_allocator
  import btbma_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  // Control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;        // live entries, always a prefix of the table
  logic [CNT_W-1:0]  idx_r, idx_nxt;        // table walk position
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;        // bit pointer for clearing
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  in_item_t          req_r, req_nxt;
  logic [SUM_W-1:0]  end_r, end_nxt;
  out_item_t         out_r, out_nxt;

  // Block table and bit memory
  logic [ADDR_W-1:0] tab_start_r [MAX_BLOCKS];
  logic [LEN_W-1:0]  tab_len_r   [MAX_BLOCKS];
  logic              bit_mem     [MEM_BITS];
  logic              rdata_r;

  // Write ports
  logic              tab_we;
  logic [IDX_W-1:0]  tab_waddr;
  logic [ADDR_W-1:0] tab_wstart;
  logic [LEN_W-1:0]  tab_wlen;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;

  // Shared compare unit over the table entry at idx_r
  logic [ADDR_W-1:0] tab_s;
  logic [LEN_W-1:0]  tab_l;
  logic [SUM_W-1:0]  tab_end;
  logic [SUM_W-1:0]  alloc_base;
  logic [SUM_W-1:0]  alloc_top;
  logic [SUM_W-1:0]  req_addr_ext;
  logic              alloc_ok;
  logic              hit_rw;
  logic              hit_free;
  logic              scan_end;
  logic              zero_last;
  logic              clear_last;

  assign tab_s        = tab_start_r[idx_r[IDX_W-1:0]];
  assign tab_l        = tab_len_r[idx_r[IDX_W-1:0]];
  assign tab_end      = SUM_W'(tab_s) + SUM_W'(tab_l);
  assign alloc_base   = (cnt_r == '0) ? '0 : tab_end;
  assign alloc_top    = alloc_base + SUM_W'(req_r.length);
  assign alloc_ok     = (cnt_r != CNT_W'(MAX_BLOCKS)) && (req_r.length != '0) &&
                        (alloc_top <= SUM_W'(MEM_BITS));
  assign req_addr_ext = SUM_W'(req_r.address);
  assign hit_rw       = (req_addr_ext >= SUM_W'(tab_s)) && (req_addr_ext < tab_end);
  assign hit_free     = (tab_s == req_r.address);
  assign scan_end     = (idx_r == cnt_r);
  assign zero_last    = ((SUM_W'(ptr_r) + SUM_W'(1)) == end_r);
  assign clear_last   = (ptr_r == ADDR_W'(MEM_BITS - 1));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = (in_data.mode == MODE_ALLOC) ? S_LAST : S_SCAN;
      end
      S_LAST: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_IDLE;
        end else if (req_r.mode == MODE_FREE) begin
          if (hit_free) state_nxt = S_ZERO;
        end else if (hit_rw) begin
          state_nxt = (req_r.mode == MODE_READ) ? S_READ : S_IDLE;
        end
      end
      S_ZERO: begin
        if (zero_last) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (idx_r >= cnt_r) state_nxt = S_IDLE;
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    req_nxt       = req_r;
    end_nxt       = end_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    tab_we        = 1'b0;
    tab_waddr     = cnt_r[IDX_W-1:0];
    tab_wstart    = alloc_base[ADDR_W-1:0];
    tab_wlen      = req_r.length;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        // Sweep the bit memory to zero, one entry per cycle
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          idx_nxt = (in_data.mode == MODE_ALLOC) ? cnt_r - CNT_W'(1) : '0;
        end
      end
      S_LAST: begin
        // Append after the last live block
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        if (alloc_ok) begin
          tab_we                  = 1'b1;
          cnt_nxt                 = cnt_r + CNT_W'(1);
          out_nxt.granted_address = alloc_base[ADDR_W-1:0];
          out_nxt.status          = ST_OK;
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = ST_MISS;
        end else if (req_r.mode == MODE_FREE) begin
          if (hit_free) begin
            ptr_nxt = tab_s;
            end_nxt = tab_end;
          end
          idx_nxt = idx_r + CNT_W'(1);
        end else if (hit_rw) begin
          if (req_r.mode == MODE_WRITE) begin
            mem_we         = 1'b1;
            mem_waddr      = req_r.address;
            mem_wdata      = req_r.bit_value;
            out_valid_nxt  = 1'b1;
            out_nxt        = '0;
            out_nxt.status = ST_OK;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_ZERO: begin
        // Clear the freed block's bits
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      S_SHIFT: begin
        // Pull later entries down one slot to close the gap
        if (idx_r < cnt_r) begin
          tab_we     = 1'b1;
          tab_waddr  = IDX_W'(idx_r - CNT_W'(1));
          tab_wstart = tab_s;
          tab_wlen   = tab_l;
          idx_nxt    = idx_r + CNT_W'(1);
        end else begin
          cnt_nxt        = cnt_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = ST_OK;
        end
      end
      S_READ: begin
        out_valid_nxt    = 1'b1;
        out_nxt          = '0;
        out_nxt.read_bit = rdata_r;
        out_nxt.status   = ST_OK;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      idx_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    end_r <= end_nxt;
    out_r <= out_nxt;
  end

  // Block table write port
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_start_r[tab_waddr] <= tab_wstart;
      tab_len_r[tab_waddr]   <= tab_wlen;
    end
  end

  // Bit memory: one write port, one registered read at the held request address
  always_ff @(posedge clk) begin
    if (mem_we) bit_mem[mem_waddr] <= mem_wdata;
    rdata_r <= bit_mem[req_r.address];
  end

  `BTA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(MAX_BLOCKS), "live count above table size")
  `BTA_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `BTA_ASSERT_NOW(a_zero_bound, state_r == S_ZERO, SUM_W'(ptr_r) < end_r, "clear past block end")
  `BTA_ASSERT_NEXT(a_alloc_count, (state_r == S_LAST) && alloc_ok, cnt_r == $past(cnt_r) + CNT_W'(1), "allocate did not add entry")

endmodule

`default_nettype wire
